// ===== rtl/core/cleb_pkg.sv =====
// ----------------------------------------------------------------------------
// cleb_pkg: shared types and codes for the console line edit buffer
// Key codes, result codes and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package cleb_pkg;

  // Item opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Control keys
  localparam logic [7:0] KEY_NUL  = 8'h00;
  localparam logic [7:0] KEY_EOF  = 8'h04;  // ctrl-D
  localparam logic [7:0] KEY_BS   = 8'h08;  // ctrl-H
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_DUMP = 8'h10;  // ctrl-P
  localparam logic [7:0] KEY_KILL = 8'h15;  // ctrl-U
  localparam logic [7:0] KEY_DEL  = 8'h7F;

  // Echo kinds
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  // Read status codes
  localparam logic [1:0] RD_NONE  = 2'd0;
  localparam logic [1:0] RD_BYTE  = 2'd1;
  localparam logic [1:0] RD_EOF   = 2'd2;
  localparam logic [1:0] RD_EMPTY = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // latch request fields and fetch the byte at the read index
    logic exec;  // evaluate request, update indices and store, register result
  } cleb_cmd_t;

endpackage

// ===== rtl/core/cleb_ctrl.sv =====
// ----------------------------------------------------------------------------
// cleb_ctrl: request sequencer
// Accepts one request, runs it through the execute step and strobes the result.
// ----------------------------------------------------------------------------
module cleb_ctrl
  import cleb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output cleb_cmd_t cmd,
  output logic      out_valid
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic valid_r;
  logic valid_nxt;
  logic accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drive datapath commands
  assign cmd.load = accept;
  assign cmd.exec = (state_r == ST_EXEC);

  // Strobe the result in the cycle after execute
  assign valid_nxt = cmd.exec;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== rtl/core/cleb_dpath.sv =====
// ----------------------------------------------------------------------------
// cleb_dpath: ring store, indices and result registers
// Holds the line ring with read, commit and edit indices and evaluates requests.
// ----------------------------------------------------------------------------
module cleb_dpath
  import cleb_pkg::*;
#(
  parameter int LINE_DEPTH = 128
)(
  input  logic       clk,
  input  logic       rst_n,
  input  cleb_cmd_t  cmd,
  input  logic       in_opcode,
  input  logic [7:0] in_key_code,
  input  logic       in_read_first,
  output logic [1:0] out_echo_kind,
  output logic [7:0] out_echo_char,
  output logic [7:0] out_erase_count,
  output logic       out_line_commit,
  output logic       out_dump_request,
  output logic [1:0] out_read_status,
  output logic [7:0] out_read_byte
);

  localparam int SPAN = 2 * LINE_DEPTH;
  localparam int IW   = $clog2(SPAN);
  localparam int SW   = $clog2(LINE_DEPTH);

  // Index helpers: indices count modulo twice the depth
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
    return (x == IW'(SPAN - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
    return (x == '0) ? IW'(SPAN - 1) : x - 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
    logic [IW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[IW]) d = d + (IW+1)'(SPAN);
    return d[IW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [IW-1:0] x);
    logic [IW-1:0] y;
    y = (x >= IW'(LINE_DEPTH)) ? x - IW'(LINE_DEPTH) : x;
    return y[SW-1:0];
  endfunction

  // Ring store
  logic [7:0] line_mem_r [LINE_DEPTH];
  logic [7:0] rdata_r;

  // Indices
  logic [IW-1:0] read_idx_r, read_idx_nxt;
  logic [IW-1:0] commit_idx_r, commit_idx_nxt;
  logic [IW-1:0] edit_idx_r, edit_idx_nxt;

  // Latched request
  logic       op_r;
  logic [7:0] key_r;
  logic       first_r;

  // Result
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] ech_r, ech_nxt;
  logic [7:0] ecount_r, ecount_nxt;
  logic       commit_r, commit_nxt;
  logic       dump_r, dump_nxt;
  logic [1:0] rstat_r, rstat_nxt;
  logic [7:0] rbyte_r, rbyte_nxt;

  // Store write
  logic          wr_en;
  logic [SW-1:0] wr_slot;
  logic [7:0]    wr_data;

  logic [IW-1:0] kill_count;
  logic [IW-1:0] fill_count;
  logic [7:0]    mapped_key;

  assign kill_count = idx_diff(edit_idx_r, commit_idx_r);
  assign fill_count = idx_diff(edit_idx_r, read_idx_r);
  assign mapped_key = (key_r == KEY_CR) ? KEY_LF : key_r;
  assign wr_slot    = slot_of(edit_idx_r);
  assign wr_data    = mapped_key;

  // Evaluate the latched request
  always_comb begin
    read_idx_nxt   = read_idx_r;
    commit_idx_nxt = commit_idx_r;
    edit_idx_nxt   = edit_idx_r;
    wr_en          = 1'b0;
    kind_nxt       = ECHO_NONE;
    ech_nxt        = 8'h00;
    ecount_nxt     = 8'h00;
    commit_nxt     = 1'b0;
    dump_nxt       = 1'b0;
    rstat_nxt      = RD_NONE;
    rbyte_nxt      = 8'h00;
    if (op_r == OP_KEY) begin
      if (key_r == KEY_DUMP) begin
        dump_nxt = 1'b1;
      end else if (key_r == KEY_KILL) begin
        // drop the whole uncommitted tail
        if (kill_count != '0) begin
          kind_nxt     = ECHO_ERASE;
          ecount_nxt   = (32'(kill_count) > 32'd255) ? 8'hFF : 8'(kill_count);
          edit_idx_nxt = commit_idx_r;
        end
      end else if (key_r == KEY_BS || key_r == KEY_DEL) begin
        // drop one uncommitted byte
        if (edit_idx_r != commit_idx_r) begin
          edit_idx_nxt = idx_dec(edit_idx_r);
          kind_nxt     = ECHO_ERASE;
          ecount_nxt   = 8'd1;
        end
      end else if (key_r != KEY_NUL && 32'(fill_count) < 32'(LINE_DEPTH)) begin
        // append, commit on newline, end of file or last free slot
        wr_en        = 1'b1;
        edit_idx_nxt = idx_inc(edit_idx_r);
        kind_nxt     = ECHO_CHAR;
        ech_nxt      = mapped_key;
        if (mapped_key == KEY_LF || mapped_key == KEY_EOF ||
            32'(fill_count) == 32'(LINE_DEPTH - 1)) begin
          commit_idx_nxt = idx_inc(edit_idx_r);
          commit_nxt     = 1'b1;
        end
      end
    end else begin
      if (read_idx_r == commit_idx_r) begin
        rstat_nxt = RD_EMPTY;
      end else if (rdata_r == KEY_EOF) begin
        // end of file is consumed only at the start of a request
        rstat_nxt = RD_EOF;
        if (first_r) read_idx_nxt = idx_inc(read_idx_r);
      end else begin
        rstat_nxt    = RD_BYTE;
        rbyte_nxt    = rdata_r;
        read_idx_nxt = idx_inc(read_idx_r);
      end
    end
  end

  // Store access: fetch on accept, write on execute
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) line_mem_r[wr_slot] <= wr_data;
    if (cmd.load) rdata_r <= line_mem_r[slot_of(read_idx_r)];
  end

  // Latch request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      key_r   <= in_key_code;
      first_r <= in_read_first;
    end
  end

  // Hold result for the strobe cycle
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      kind_r   <= kind_nxt;
      ech_r    <= ech_nxt;
      ecount_r <= ecount_nxt;
      commit_r <= commit_nxt;
      dump_r   <= dump_nxt;
      rstat_r  <= rstat_nxt;
      rbyte_r  <= rbyte_nxt;
    end
  end

  // Advance indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_idx_r   <= '0;
      commit_idx_r <= '0;
      edit_idx_r   <= '0;
    end else if (cmd.exec) begin
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
    end
  end

  assign out_echo_kind    = kind_r;
  assign out_echo_char    = ech_r;
  assign out_erase_count  = ecount_r;
  assign out_line_commit  = commit_r;
  assign out_dump_request = dump_r;
  assign out_read_status  = rstat_r;
  assign out_read_byte    = rbyte_r;

endmodule

// ===== rtl/core/console_line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// console_line_edit_buffer: canonical keyboard line buffer
// Line editing over a ring store with read, commit and edit indices.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request yields
// exactly one result, shown for one cycle with out_valid high after the
// request passes the execute state and the valid register; the receiver
// cannot stall it. busy is high in the execute state, so no new
// request is taken while one executes. The ring store read data is registered,
// so the byte at the read index is fetched in the accept cycle and used the
// next. After reset the line is empty and no clearing pass is needed.
module console_line_edit_buffer
  import cleb_pkg::*;
#(
  parameter int LINE_DEPTH = 128
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_opcode,
  input  logic [7:0] in_key_code,
  input  logic       in_read_first,
  output logic       out_valid,
  output logic [1:0] out_echo_kind,
  output logic [7:0] out_echo_char,
  output logic [7:0] out_erase_count,
  output logic       out_line_commit,
  output logic       out_dump_request,
  output logic [1:0] out_read_status,
  output logic [7:0] out_read_byte
);

  cleb_cmd_t cmd;

  // Sequence requests
  cleb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // Store and evaluate
  cleb_dpath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_opcode),
    .in_key_code      (in_key_code),
    .in_read_first    (in_read_first),
    .out_echo_kind    (out_echo_kind),
    .out_echo_char    (out_echo_char),
    .out_erase_count  (out_erase_count),
    .out_line_commit  (out_line_commit),
    .out_dump_request (out_dump_request),
    .out_read_status  (out_read_status),
    .out_read_byte    (out_read_byte)
  );

endmodule

// ===== sim/tb_console_line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_console_line_edit_buffer: self-checking bench for the line edit buffer
// Walks a short table of directed requests and then random line, drain, fill
// and noise sequences. Each result is scored against a typed-in table value or
// an in-bench model of the ring store and its read, commit and edit indices.
// ----------------------------------------------------------------------------
module tb_console_line_edit_buffer;
  import cleb_pkg::*;

  localparam int LINE_DEPTH   = 128;
  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_ITEMS  = 150;
  localparam int IDLE_LIMIT   = 400;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic       op;
    logic [7:0] key;
    logic       first;
  } line_req_t;

  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_commit;
    logic       dump_request;
    logic [1:0] read_status;
    logic [7:0] read_byte;
  } line_res_t;

  typedef struct packed {
    line_req_t req;
    logic      fixed;
    line_res_t res;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_opcode;
  logic [7:0] in_key_code;
  logic       in_read_first;
  logic       out_valid;
  logic [1:0] out_echo_kind;
  logic [7:0] out_echo_char;
  logic [7:0] out_erase_count;
  logic       out_line_commit;
  logic       out_dump_request;
  logic [1:0] out_read_status;
  logic [7:0] out_read_byte;

  // typed-in expectation travelling alongside the request being offered
  logic      fix_valid;
  line_res_t fix_res;

  // model copy of the ring and its indices (modulo twice the depth)
  logic [7:0] line_ring [LINE_DEPTH];
  logic [7:0] rd_ptr;
  logic [7:0] cm_ptr;
  logic [7:0] ed_ptr;

  line_res_t pending_res [$];
  dir_row_t  dir_rows [$];

  int  err_cnt    = 0;
  int  req_cnt    = 0;
  int  res_cnt    = 0;
  int  commit_cnt = 0;
  int  eof_cnt    = 0;
  int  erase_cnt  = 0;
  int  idle_cnt   = 0;
  int  sent_cnt   = 0;
  bit  quiet      = 1'b0;
  bit  idle_on    = 1'b1;

  console_line_edit_buffer #(
    .LINE_DEPTH(LINE_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_key_code      (in_key_code),
    .in_read_first    (in_read_first),
    .out_valid        (out_valid),
    .out_echo_kind    (out_echo_kind),
    .out_echo_char    (out_echo_char),
    .out_erase_count  (out_erase_count),
    .out_line_commit  (out_line_commit),
    .out_dump_request (out_dump_request),
    .out_read_status  (out_read_status),
    .out_read_byte    (out_read_byte)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Build a result from its fields for the directed table
  function automatic line_res_t mk_res(logic [1:0] kind, logic [7:0] ch, logic [7:0] cnt,
                                       logic commit, logic dump, logic [1:0] rs,
                                       logic [7:0] rb);
    line_res_t r;
    r.echo_kind    = kind;
    r.echo_char    = ch;
    r.erase_count  = cnt;
    r.line_commit  = commit;
    r.dump_request = dump;
    r.read_status  = rs;
    r.read_byte    = rb;
    return r;
  endfunction

  // Advance the line model by one request and return what it should report
  function automatic line_res_t predict_line(line_req_t r);
    line_res_t  res;
    logic [7:0] fill_lvl;
    logic [7:0] pend;
    logic [7:0] c;
    res = '0;
    if (r.op == OP_KEY) begin
      fill_lvl = ed_ptr - rd_ptr;
      pend     = ed_ptr - cm_ptr;
      if (r.key == KEY_DUMP) begin
        res.dump_request = 1'b1;
      end else if (r.key == KEY_KILL) begin
        // kill the whole uncommitted tail
        if (pend != 8'd0) begin
          res.echo_kind   = ECHO_ERASE;
          res.erase_count = pend;
          ed_ptr          = cm_ptr;
        end
      end else if (r.key == KEY_BS || r.key == KEY_DEL) begin
        if (ed_ptr != cm_ptr) begin
          ed_ptr          = ed_ptr - 8'd1;
          res.echo_kind   = ECHO_ERASE;
          res.erase_count = 8'd1;
        end
      end else if (r.key != KEY_NUL && fill_lvl < LINE_DEPTH) begin
        // append, mapping CR to LF; commit on LF, EOF or last free slot
        c = (r.key == KEY_CR) ? KEY_LF : r.key;
        line_ring[ed_ptr[6:0]] = c;
        ed_ptr        = ed_ptr + 8'd1;
        res.echo_kind = ECHO_CHAR;
        res.echo_char = c;
        fill_lvl      = ed_ptr - rd_ptr;
        if (c == KEY_LF || c == KEY_EOF || fill_lvl == LINE_DEPTH) begin
          cm_ptr          = ed_ptr;
          res.line_commit = 1'b1;
        end
      end
    end else begin
      if (rd_ptr == cm_ptr) begin
        res.read_status = RD_EMPTY;
      end else begin
        c = line_ring[rd_ptr[6:0]];
        if (c == KEY_EOF) begin
          // EOF is only consumed at the head of a request
          res.read_status = RD_EOF;
          if (r.first) rd_ptr = rd_ptr + 8'd1;
        end else begin
          res.read_status = RD_BYTE;
          res.read_byte   = c;
          rd_ptr          = rd_ptr + 8'd1;
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Offer one request, hold it until taken, then maybe idle for a burst
  task automatic issue(input line_req_t r, input logic fixed, input line_res_t fres);
    in_opcode     <= r.op;
    in_key_code   <= r.key;
    in_read_first <= r.first;
    fix_valid     <= fixed;
    fix_res       <= fres;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sent_cnt++;
    if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_key(input logic [7:0] k);
    line_req_t r;
    r.op    = OP_KEY;
    r.key   = k;
    r.first = 1'($urandom_range(0, 1));
    issue(r, 1'b0, '0);
  endtask

  task automatic send_read(input logic first);
    line_req_t r;
    r.op    = OP_READ;
    r.key   = 8'($urandom_range(0, 255));
    r.first = first;
    issue(r, 1'b0, '0);
  endtask

  task automatic add_row(input logic op, input logic [7:0] key, input logic first,
                         input logic fixed, input line_res_t res);
    dir_row_t row;
    row.req.op    = op;
    row.req.key   = key;
    row.req.first = first;
    row.fixed     = fixed;
    row.res       = res;
    dir_rows.push_back(row);
  endtask

  // Score results, then take new requests into the model; watch for stalls
  always @(posedge clk) begin : score
    line_res_t exp_r;
    line_res_t got_r;
    line_req_t req;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_res.size() == 0) begin
          $error("result seen with no request outstanding");
          err_cnt++;
        end else begin
          exp_r = pending_res.pop_front();
          check_field("echo_kind",    8'(exp_r.echo_kind),    8'(out_echo_kind));
          check_field("echo_char",    exp_r.echo_char,        out_echo_char);
          check_field("erase_count",  exp_r.erase_count,      out_erase_count);
          check_field("line_commit",  8'(exp_r.line_commit),  8'(out_line_commit));
          check_field("dump_request", 8'(exp_r.dump_request), 8'(out_dump_request));
          check_field("read_status",  8'(exp_r.read_status),  8'(out_read_status));
          check_field("read_byte",    exp_r.read_byte,        out_read_byte);
          res_cnt++;
          if (exp_r.line_commit) commit_cnt++;
          if (exp_r.read_status == RD_EOF) eof_cnt++;
          if (exp_r.echo_kind == ECHO_ERASE) erase_cnt++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        req.op    = in_opcode;
        req.key   = in_key_code;
        req.first = in_read_first;
        got_r     = predict_line(req);
        pending_res.push_back(fix_valid ? fix_res : got_r);
        req_cnt++;
      end
    end
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : stim
    int         rand_sent;
    int         n;
    int         sel;
    logic [7:0] k;
    start         = 1'b0;
    in_opcode     = OP_KEY;
    in_key_code   = 8'h00;
    in_read_first = 1'b0;
    fix_valid     = 1'b0;
    fix_res       = '0;
    rd_ptr        = 8'd0;
    cm_ptr        = 8'd0;
    ed_ptr        = 8'd0;
    foreach (line_ring[i]) line_ring[i] = 8'h00;
    rst_n         = 1'b0;

    // directed rows: empty line edits, extremes, commit keys and EOF reads
    add_row(OP_READ, 8'h00, 1'b1, 1'b1, mk_res(ECHO_NONE, '0, '0, '0, '0, RD_EMPTY, '0));
    add_row(OP_KEY,  KEY_NUL, 1'b0, 1'b1, mk_res(ECHO_NONE, '0, '0, '0, '0, RD_NONE, '0));
    add_row(OP_KEY,  KEY_BS,  1'b1, 1'b1, mk_res(ECHO_NONE, '0, '0, '0, '0, RD_NONE, '0));
    add_row(OP_KEY,  KEY_KILL, 1'b0, 1'b1, mk_res(ECHO_NONE, '0, '0, '0, '0, RD_NONE, '0));
    add_row(OP_KEY,  KEY_DUMP, 1'b0, 1'b1,
            mk_res(ECHO_NONE, '0, '0, '0, 1'b1, RD_NONE, '0));
    add_row(OP_KEY,  8'h61, 1'b0, 1'b1, mk_res(ECHO_CHAR, 8'h61, '0, '0, '0, RD_NONE, '0));
    add_row(OP_KEY,  8'hFF, 1'b1, 1'b1, mk_res(ECHO_CHAR, 8'hFF, '0, '0, '0, RD_NONE, '0));
    add_row(OP_KEY,  KEY_DEL, 1'b0, 1'b1,
            mk_res(ECHO_ERASE, '0, 8'd1, '0, '0, RD_NONE, '0));
    add_row(OP_KEY,  8'h80, 1'b0, 1'b0, '0);
    add_row(OP_KEY,  KEY_KILL, 1'b0, 1'b0, '0);
    add_row(OP_KEY,  8'h78, 1'b0, 1'b0, '0);
    add_row(OP_KEY,  KEY_CR, 1'b0, 1'b1,
            mk_res(ECHO_CHAR, KEY_LF, '0, 1'b1, '0, RD_NONE, '0));
    add_row(OP_READ, 8'h00, 1'b1, 1'b0, '0);
    add_row(OP_READ, 8'h55, 1'b0, 1'b0, '0);
    add_row(OP_READ, 8'hFF, 1'b0, 1'b1, mk_res(ECHO_NONE, '0, '0, '0, '0, RD_EMPTY, '0));
    add_row(OP_KEY,  8'h71, 1'b0, 1'b0, '0);
    add_row(OP_KEY,  KEY_EOF, 1'b0, 1'b1,
            mk_res(ECHO_CHAR, KEY_EOF, '0, 1'b1, '0, RD_NONE, '0));
    add_row(OP_READ, 8'h00, 1'b1, 1'b0, '0);
    add_row(OP_READ, 8'h00, 1'b0, 1'b0, '0);
    add_row(OP_READ, 8'hAA, 1'b0, 1'b0, '0);
    add_row(OP_READ, 8'h00, 1'b1, 1'b0, '0);
    add_row(OP_READ, 8'h00, 1'b1, 1'b1, mk_res(ECHO_NONE, '0, '0, '0, '0, RD_EMPTY, '0));
    add_row(OP_KEY,  8'h1B, 1'b0, 1'b0, '0);
    add_row(OP_KEY,  KEY_LF, 1'b0, 1'b0, '0);
    add_row(OP_READ, 8'h00, 1'b1, 1'b0, '0);

    // hold reset, then release it
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // walk the directed table
    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);

    // random sequences, mostly well-formed lines and drains
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      n       = sent_cnt;
      quiet   = (rand_sent >= RANDOM_ITEMS - QUIET_ITEMS);
      idle_on = ($urandom_range(0, 3) != 0);
      sel     = $urandom_range(0, 99);
      if (sel < 45) begin
        // a typed line with edits and a terminator, or left open
        repeat ($urandom_range(0, 20)) begin
          sel = $urandom_range(0, 19);
          if (sel < 12)       k = 8'($urandom_range(8'h20, 8'h7E));
          else if (sel < 15)  k = 8'($urandom_range(1, 255));
          else if (sel == 15) k = KEY_BS;
          else if (sel < 18)  k = KEY_DEL;
          else if (sel == 18) k = 8'h1B;
          else                k = KEY_KILL;
          send_key(k);
        end
        sel = $urandom_range(0, 9);
        if (sel < 4)      send_key(KEY_CR);
        else if (sel < 7) send_key(KEY_LF);
        else if (sel < 9) send_key(KEY_EOF);
      end else if (sel < 82) begin
        // one read of one to 24 bytes, one request per byte
        n = $urandom_range(1, 24);
        for (int j = 0; j < n; j++) send_read(j == 0);
        n = sent_cnt;
      end else if (sel < 84) begin
        // fill the ring past full, then drain it
        repeat ($urandom_range(LINE_DEPTH, LINE_DEPTH + 8))
          send_key(8'($urandom_range(8'h20, 8'h7E)));
        for (int j = 0; j < LINE_DEPTH + 4; j++) send_read(j == 0);
        n = sent_cnt - LINE_DEPTH - 4;
        n = n - 0;
      end else begin
        // noise: anything at all
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1) == 0) send_key(8'($urandom_range(0, 255)));
          else send_read(1'($urandom_range(0, 1)));
        end
      end
      rand_sent = sent_cnt - dir_rows.size();
    end

    // drop start and let the last results arrive
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d results scored: %0d line commits,",
             req_cnt, res_cnt, commit_cnt);
    $display("%0d erase echoes and %0d end-of-file reads.", erase_cnt, eof_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cleb_pkg.sv
rtl/core/cleb_ctrl.sv
rtl/core/cleb_dpath.sv
rtl/core/console_line_edit_buffer.sv
sim/tb_console_line_edit_buffer.sv
